FILE: rtl/core/fcms_pkg.sv
`timescale 1ns / 1ps
// shared widths and control/status bundles for the frequency conversion
// multiplier/shift block; no dependencies

package fcms_pkg;

  localparam int unsigned FREQ_W  = 64;
  localparam int unsigned SHIFT_W = 7;
  localparam int unsigned LZ_W    = 6;
  localparam int unsigned CNT_W   = 6;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture a new input beat
    logic norm;      // one normalization step
    logic prep;      // compare normalized operands, set up the division
    logic div;       // one restoring division step
    logic out_load;  // move the result into the output register
  } fcms_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_bad;     // incoming beat has a zero operand
    logic bad;        // captured beat has a zero operand
    logic norm_done;  // both operands have their msb set
    logic div_last;   // final division step
  } fcms_status_t;

endpackage

FILE: rtl/core/fcms_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the input and result beats
// depends on fcms_pkg for field widths

interface fcms_in_if;
  logic                              valid;
  logic                              ready;
  logic [fcms_pkg::FREQ_W-1:0]       source_frequency;
  logic [fcms_pkg::FREQ_W-1:0]       target_frequency;

  modport source (output valid, output source_frequency, output target_frequency,
                  input ready);
  modport sink   (input valid, input source_frequency, input target_frequency,
                  output ready);
endinterface

interface fcms_out_if;
  logic                              valid;
  logic                              ready;
  logic [fcms_pkg::FREQ_W-1:0]       scale_multiplier;
  logic [fcms_pkg::SHIFT_W-1:0]      scale_shift;
  logic                              bad_operand;

  modport source (output valid, output scale_multiplier, output scale_shift,
                  output bad_operand, input ready);
  modport sink   (input valid, input scale_multiplier, input scale_shift,
                  input bad_operand, output ready);
endinterface

FILE: rtl/core/fcms_datapath.sv
`timescale 1ns / 1ps
// operand normalization, shift computation, serial 128/64 divider and
// result register; depends on fcms_pkg

module fcms_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fcms_pkg::fcms_cmd_t           cmd_i,
  output fcms_pkg::fcms_status_t        status_o,
  input  logic [fcms_pkg::FREQ_W-1:0]   src_i,
  input  logic [fcms_pkg::FREQ_W-1:0]   dst_i,
  output logic [fcms_pkg::FREQ_W-1:0]   mult_o,
  output logic [fcms_pkg::SHIFT_W-1:0]  shift_o,
  output logic                          bad_o
);

  logic [fcms_pkg::FREQ_W-1:0]  src_q, src_d;
  logic [fcms_pkg::FREQ_W-1:0]  dst_q, dst_d;
  logic [fcms_pkg::LZ_W-1:0]    lzs_q, lzs_d;
  logic [fcms_pkg::LZ_W-1:0]    lzd_q, lzd_d;
  logic                         bad_q, bad_d;
  logic [fcms_pkg::FREQ_W-1:0]  rem_q, rem_d;
  logic [fcms_pkg::FREQ_W-1:0]  quo_q, quo_d;
  logic [fcms_pkg::SHIFT_W-1:0] shift_q, shift_d;
  logic [fcms_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [fcms_pkg::FREQ_W-1:0]  mult_out_q, mult_out_d;
  logic [fcms_pkg::SHIFT_W-1:0] shift_out_q, shift_out_d;
  logic                         bad_out_q, bad_out_d;

  logic                         over;
  logic [fcms_pkg::FREQ_W:0]    trial;
  logic [fcms_pkg::FREQ_W:0]    diff;
  logic                         qbit;

  // normalized target not below normalized source: quotient needs one less shift
  assign over  = (dst_q >= src_q);
  assign trial = {rem_q, quo_q[fcms_pkg::FREQ_W-1]};
  assign diff  = trial - {1'b0, src_q};
  assign qbit  = (trial >= {1'b0, src_q});

  always_comb begin
    src_d       = src_q;
    dst_d       = dst_q;
    lzs_d       = lzs_q;
    lzd_d       = lzd_q;
    bad_d       = bad_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    shift_d     = shift_q;
    cnt_d       = cnt_q;
    mult_out_d  = mult_out_q;
    shift_out_d = shift_out_q;
    bad_out_d   = bad_out_q;

    if (cmd_i.load) begin
      src_d = src_i;
      dst_d = dst_i;
      lzs_d = '0;
      lzd_d = '0;
      bad_d = status_o.in_bad;
    end

    if (cmd_i.norm) begin
      if (!src_q[fcms_pkg::FREQ_W-1]) begin
        src_d = {src_q[fcms_pkg::FREQ_W-2:0], 1'b0};
        lzs_d = lzs_q + 1'b1;
      end
      if (!dst_q[fcms_pkg::FREQ_W-1]) begin
        dst_d = {dst_q[fcms_pkg::FREQ_W-2:0], 1'b0};
        lzd_d = lzd_q + 1'b1;
      end
    end

    if (cmd_i.prep) begin
      // dividend is the normalized target placed at bit 127 or bit 126
      if (over) begin
        rem_d = {1'b0, dst_q[fcms_pkg::FREQ_W-1:1]};
        quo_d = {dst_q[0], {(fcms_pkg::FREQ_W-1){1'b0}}};
      end else begin
        rem_d = dst_q;
        quo_d = '0;
      end
      shift_d = fcms_pkg::SHIFT_W'(lzd_q) + fcms_pkg::SHIFT_W'(fcms_pkg::FREQ_W)
              - fcms_pkg::SHIFT_W'(lzs_q) - fcms_pkg::SHIFT_W'(over);
      cnt_d   = '1;
    end

    if (cmd_i.div) begin
      // low dividend bits shift out of quo_q as quotient bits shift in
      rem_d = qbit ? diff[fcms_pkg::FREQ_W-1:0] : trial[fcms_pkg::FREQ_W-1:0];
      quo_d = {quo_q[fcms_pkg::FREQ_W-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
    end

    if (cmd_i.out_load) begin
      mult_out_d  = bad_q ? '0 : quo_q;
      shift_out_d = bad_q ? '0 : shift_q;
      bad_out_d   = bad_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      bad_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      bad_q <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q       <= src_d;
    dst_q       <= dst_d;
    lzs_q       <= lzs_d;
    lzd_q       <= lzd_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    shift_q     <= shift_d;
    mult_out_q  <= mult_out_d;
    shift_out_q <= shift_out_d;
    bad_out_q   <= bad_out_d;
  end

  assign status_o.in_bad    = (src_i == '0) || (dst_i == '0);
  assign status_o.bad       = bad_q;
  assign status_o.norm_done = src_q[fcms_pkg::FREQ_W-1] && dst_q[fcms_pkg::FREQ_W-1];
  assign status_o.div_last  = (cnt_q == '0);

  assign mult_o  = mult_out_q;
  assign shift_o = shift_out_q;
  assign bad_o   = bad_out_q;

endmodule

FILE: rtl/core/fcms_ctrl.sv
`timescale 1ns / 1ps
// sequencer for normalize, prepare, divide and result hand-off
// depends on fcms_pkg

module fcms_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output fcms_pkg::fcms_cmd_t     cmd_o,
  input  fcms_pkg::fcms_status_t  status_i
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StNorm = 5'b00010,
    StPrep = 5'b00100,
    StDiv  = 5'b01000,
    StFin  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   out_free;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_bad ? StFin : StNorm;
        end
      end
      StNorm: begin
        if (status_i.norm_done) begin
          state_d = StPrep;
        end else begin
          cmd_o.norm = 1'b1;
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = StDiv;
      end
      StDiv: begin
        cmd_o.div = 1'b1;
        if (status_i.div_last) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while pending");

  // a zero operand skips the divider entirely
  a_bad_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && status_i.in_bad) |=> (state_q == StFin && status_i.bad))
    else $error("zero operand beat did not go straight to hand-off");

  // last division step leads to hand-off
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && status_i.div_last) |=> (state_q == StFin))
    else $error("divider did not finish after its last step");

  // loading the result always raises valid
  a_out_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result loaded without valid");

endmodule

FILE: rtl/core/freq_conversion_mult_shift.sv
`timescale 1ns / 1ps
// sequence: accept, normalization until both operands have their msb set,
// prepare, the 64-step restoring division and hand-off, which waits while a
// result is still pending; a zero operand goes from accept straight to hand-off.
// throughput: one beat at a time, the next accepted after the result is
// registered; the restoring divider dominates the time per beat.
// reset: asynchronous active low, returns to idle with no result pending.

module freq_conversion_mult_shift (
  input  logic        clk_i,
  input  logic        rst_ni,
  fcms_in_if.sink     in_i,
  fcms_out_if.source  out_o
);

  fcms_pkg::fcms_cmd_t    cmd;
  fcms_pkg::fcms_status_t status;

  fcms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  fcms_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .src_i    (in_i.source_frequency),
    .dst_i    (in_i.target_frequency),
    .mult_o   (out_o.scale_multiplier),
    .shift_o  (out_o.scale_shift),
    .bad_o    (out_o.bad_operand)
  );

endmodule
